FILE: src/dbrb_pkg.sv
// Package for the DRAM bank row buffer: command codes, geometry and item layout.
// Used by dram_bank_row_buffer; depends on nothing.
package dbrb_pkg;

    // Bank geometry.
    localparam int ROW_COUNT    = 1024;
    localparam int COLUMN_COUNT = 128;

    // Widths fixed by the item fields.
    localparam int OP_W   = 3;
    localparam int ROW_W  = 10;
    localparam int COL_W  = 7;
    localparam int BYTE_W = 8;

    // Row address width of the cell memory.
    localparam int ROW_AW = $clog2(ROW_COUNT);

    // Width of one full row of the cell memory.
    localparam int ROW_BITS = COLUMN_COUNT * BYTE_W;

    // Input item tdata width, rounded up to whole bytes.
    localparam int S_FIELDS_W = OP_W + ROW_W + COL_W + BYTE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // Command codes.
    typedef enum logic [OP_W-1:0] {
        OP_ACTIVATE  = 3'd0,
        OP_READ      = 3'd1,
        OP_READ_AP   = 3'd2,
        OP_WRITE     = 3'd3,
        OP_WRITE_AP  = 3'd4,
        OP_PRECHARGE = 3'd5,
        OP_REFRESH   = 3'd6,
        OP_NONE      = 3'd7
    } op_t;

    // One row as a packed array of bytes, column 0 in the lowest byte.
    typedef logic [COLUMN_COUNT-1:0][BYTE_W-1:0] row_t;

endpackage

FILE: src/dram_bank_row_buffer.sv
// DRAM bank with a one-row buffer. A read gives its item in the cycle after acceptance.
// Read, write, precharge and no-op leave the sequencer idle for the next item; activate and
// refresh pass through a load state for the registered read of the row-wide cell memory.
// Reset (aresetn, synchronous) clears the row buffer, the sequencer and the output register.
// The cell memory is not cleared: rows read back as written, unwritten rows are undefined.
// Depends on dbrb_pkg and dbrb_ram.
module dram_bank_row_buffer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata fields from bit 0 up: operation, row_index, column_index, write_byte.
    input  logic [dbrb_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // m_tdata fields from bit 0 up: read_byte.
    output logic [dbrb_pkg::BYTE_W-1:0]    m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready
);
    import dbrb_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_LOAD
    } state_t;

    state_t            state_reg, state_next;
    row_t              buf_reg, buf_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0] m_tdata_reg, m_tdata_next;

    op_t               op;
    logic [ROW_W-1:0]  row_idx;
    logic [COL_W-1:0]  col_idx;
    logic [BYTE_W-1:0] wr_byte;
    logic              row_ok;
    logic              col_ok;
    logic              s_acc;
    logic              is_read;

    row_t              merged_row;
    row_t              ram_rd_data;
    logic              ram_we;
    logic              ram_re;
    logic [ROW_AW-1:0] ram_rd_addr;

    // Unpack the input item.
    assign op      = op_t'(s_tdata[OP_W-1:0]);
    assign row_idx = s_tdata[OP_W +: ROW_W];
    assign col_idx = s_tdata[OP_W+ROW_W +: COL_W];
    assign wr_byte = s_tdata[OP_W+ROW_W+COL_W +: BYTE_W];

    assign row_ok  = 32'(row_idx) < ROW_COUNT;
    assign col_ok  = 32'(col_idx) < COLUMN_COUNT;
    assign is_read = (op == OP_READ) || (op == OP_READ_AP);

    // Take a new item only between memory loads and when the result slot can take a read.
    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign s_acc    = s_tvalid && s_tready;

    // Buffer with the write byte merged in; this is also the row written back.
    always_comb begin
        merged_row = buf_reg;
        if (col_ok) begin
            merged_row[col_idx] = wr_byte;
        end
    end

    // Each item makes at most one memory access, so a write and a later load of the
    // same row always happen at different edges and need no forwarding.
    assign ram_we = s_acc && ((op == OP_WRITE) || (op == OP_WRITE_AP)) && row_ok;
    assign ram_re = s_acc && (((op == OP_ACTIVATE) && row_ok) || (op == OP_REFRESH));
    assign ram_rd_addr = (op == OP_REFRESH) ? ROW_AW'(ROW_COUNT - 1) : ROW_AW'(row_idx);

    dbrb_ram #(
        .WIDTH(ROW_BITS),
        .DEPTH(ROW_COUNT)
    ) u_cells (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ROW_AW'(row_idx)),
        .wr_data(merged_row),
        .rd_en  (ram_re),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    // Sequencer, buffer and result slot next values.
    always_comb begin
        state_next    = state_reg;
        buf_next      = buf_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (op)
                        OP_ACTIVATE: begin
                            if (row_ok) begin
                                state_next = ST_LOAD;
                            end
                        end
                        OP_REFRESH: begin
                            state_next = ST_LOAD;
                        end
                        OP_READ, OP_READ_AP: begin
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = col_ok ? buf_reg[col_idx] : '0;
                        end
                        OP_WRITE, OP_WRITE_AP: begin
                            buf_next = merged_row;
                        end
                        OP_PRECHARGE: begin
                            buf_next = '0;
                        end
                        OP_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                // Row data from the memory arrives in the cycle after the read.
                buf_next   = ram_rd_data;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, buffer and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            buf_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            buf_reg      <= buf_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // An accepted read always shows its result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && is_read |=> m_tvalid)
        else $error("read item did not produce a result");

    // A memory load always returns the sequencer to idle in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOAD |=> state_reg == ST_IDLE)
        else $error("load state did not return to idle");

    // Activate of a valid row starts a load.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (op == OP_ACTIVATE) && row_ok |=> state_reg == ST_LOAD)
        else $error("activate did not start a row load");

    // Precharge leaves the buffer cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (op == OP_PRECHARGE) |=> buf_reg == '0)
        else $error("precharge did not clear the row buffer");

endmodule

FILE: src/dbrb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the cell array of the DRAM bank row buffer; depends on nothing.
module dbrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: dv/dram_bank_row_buffer_tb.sv
// Self-checking testbench for dram_bank_row_buffer: bank commands go in on the s_ stream,
// read bytes come out on the m_ stream. It keeps its own copy of the bank for prediction.
// Depends on dbrb_pkg and the block's RTL.
`timescale 1ns / 100ps

module dram_bank_row_buffer_tb;
    import dbrb_pkg::*;

    localparam int  RANDOM_COMMANDS = 1950;
    localparam int  DRAIN_CYCLES    = 10;
    localparam int  CYCLE_LIMIT     = 400000;
    localparam int  LAST_ROW        = ROW_COUNT - 1;
    localparam int  LAST_COL        = COLUMN_COUNT - 1;

    // One bank command as it travels on s_tdata.
    typedef struct packed {
        logic [BYTE_W-1:0] wbyte;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        op_t               op;
    } bank_cmd_t;

    // Bank predictor and read-byte checker.
    class bank_scoreboard;
        logic [BYTE_W-1:0] cells [ROW_COUNT][COLUMN_COUNT];
        logic [BYTE_W-1:0] open_row [COLUMN_COUNT];
        bit                row_written [ROW_COUNT];
        int                written_rows [$];
        logic [BYTE_W-1:0] pending_reads [$];
        int                mismatches;

        function new();
            foreach (open_row[c]) open_row[c] = '0;
            foreach (row_written[r]) row_written[r] = 1'b0;
            mismatches = 0;
        endfunction

        // Update the bank copy for one accepted command.
        function void apply_command(bank_cmd_t cmd);
            case (cmd.op)
                OP_ACTIVATE: begin
                    foreach (open_row[c]) open_row[c] = cells[cmd.row][c];
                end
                OP_READ, OP_READ_AP: begin
                    pending_reads.push_back(open_row[cmd.col]);
                end
                OP_WRITE, OP_WRITE_AP: begin
                    open_row[cmd.col] = cmd.wbyte;
                    foreach (open_row[c]) cells[cmd.row][c] = open_row[c];
                    if (!row_written[cmd.row]) begin
                        row_written[cmd.row] = 1'b1;
                        written_rows.push_back(int'(cmd.row));
                    end
                end
                OP_PRECHARGE: begin
                    foreach (open_row[c]) open_row[c] = '0;
                end
                OP_REFRESH: begin
                    foreach (open_row[c]) open_row[c] = cells[LAST_ROW][c];
                end
                default: begin
                end
            endcase
        endfunction

        function void note_failure(string what, logic [BYTE_W-1:0] want,
                                   logic [BYTE_W-1:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s: read_byte expected %h, got %h", $realtime, what, want, got);
        endfunction

        // Compare one read item with the oldest expected byte.
        function void check_read_byte(logic [BYTE_W-1:0] got);
            logic [BYTE_W-1:0] want;
            if (pending_reads.size() == 0) begin
                note_failure("unexpected read item", 'x, got);
            end else begin
                want = pending_reads.pop_front();
                if (got !== want)
                    note_failure("read mismatch", want, got);
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    bank_scoreboard sb = new();

    int  cycle_count    = 0;
    int  commands_sent  = 0;
    int  burst_left     = 0;
    int  active_row     = -1;
    int  last_write_col = 0;

    dram_bank_row_buffer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // 12 ns clock.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: phases of always-ready, a rotating stall pattern, light and heavy random stalls.
    logic [12:0] stall_pattern = 13'b1011001110101;
    int          stall_mode    = 0;
    int          phase_left    = 0;

    always @(posedge aclk) begin
        if (phase_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            phase_left = $urandom_range(20, 300);
        end else begin
            phase_left--;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: begin
                m_tready      <= stall_pattern[0];
                stall_pattern  = {stall_pattern[0], stall_pattern[12:1]};
            end
            2: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // Check every accepted read item.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_read_byte(m_tdata);
    end

    function automatic bank_cmd_t make_cmd(op_t op, int row, int col, int wbyte);
        bank_cmd_t cmd;
        cmd.op    = op;
        cmd.row   = ROW_W'(row);
        cmd.col   = COL_W'(col);
        cmd.wbyte = BYTE_W'(wbyte);
        return cmd;
    endfunction

    // Present one command, wait for its acceptance, then maybe leave a gap.
    task automatic push_cmd(bank_cmd_t cmd);
        int gap;
        s_tdata  <= S_TDATA_W'(cmd);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.apply_command(cmd);
        if (cmd.op != OP_NONE)
            commands_sent++;
        if (cmd.op == OP_ACTIVATE)
            active_row = int'(cmd.row);
        if (cmd.op == OP_WRITE || cmd.op == OP_WRITE_AP)
            last_write_col = int'(cmd.col);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 16);
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    function automatic int pick_col();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return LAST_COL;
            2, 3: return last_write_col;
            default: return $urandom_range(0, LAST_COL);
        endcase
    endfunction

    function automatic int pick_written_row();
        return sb.written_rows[$urandom_range(0, sb.written_rows.size() - 1)];
    endfunction

    // A write row: mostly the open row, else one already in use, else any row.
    function automatic int pick_write_row();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6 && active_row >= 0)
            return active_row;
        if (sel < 8 && sb.written_rows.size() != 0)
            return pick_written_row();
        return $urandom_range(0, LAST_ROW);
    endfunction

    // One command inside an open-row sequence.
    task automatic push_access();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 9)
            push_cmd(make_cmd(sel[0] ? OP_READ : OP_READ_AP, 0, pick_col(), 0));
        else if (sel < 18)
            push_cmd(make_cmd(sel[0] ? OP_WRITE : OP_WRITE_AP, pick_write_row(), pick_col(),
                              $urandom_range(0, 255)));
        else if (sb.row_written[LAST_ROW])
            push_cmd(make_cmd(OP_REFRESH, $urandom_range(0, LAST_ROW), pick_col(),
                              $urandom_range(0, 255)));
        else
            push_cmd(make_cmd(OP_READ, 0, pick_col(), 0));
    endtask

    // A single command with any code; activate and refresh only touch written rows.
    task automatic push_noise();
        op_t op;
        int  row;
        op  = op_t'($urandom_range(0, 7));
        row = $urandom_range(0, LAST_ROW);
        if (op == OP_ACTIVATE && !sb.row_written[row])
            row = pick_written_row();
        if (op == OP_REFRESH && !sb.row_written[LAST_ROW])
            op = OP_PRECHARGE;
        push_cmd(make_cmd(op, row, $urandom_range(0, LAST_COL), $urandom_range(0, 255)));
    endtask

    // Directed: field extremes, every code, writes to a row that is not open, refresh.
    task automatic run_directed();
        push_cmd(make_cmd(OP_NONE, LAST_ROW, LAST_COL, 8'hFF));
        push_cmd(make_cmd(OP_READ, 0, 0, 0));
        push_cmd(make_cmd(OP_READ_AP, LAST_ROW, LAST_COL, 8'hFF));
        push_cmd(make_cmd(OP_WRITE, LAST_ROW, LAST_COL, 8'hFF));
        push_cmd(make_cmd(OP_WRITE_AP, 0, 0, 8'h00));
        push_cmd(make_cmd(OP_WRITE, 512, 64, 8'h5A));
        push_cmd(make_cmd(OP_PRECHARGE, LAST_ROW, LAST_COL, 8'hFF));
        push_cmd(make_cmd(OP_READ, 0, LAST_COL, 0));
        push_cmd(make_cmd(OP_REFRESH, 0, 0, 0));
        push_cmd(make_cmd(OP_READ, 0, LAST_COL, 0));
        push_cmd(make_cmd(OP_READ_AP, 0, 64, 0));
        push_cmd(make_cmd(OP_ACTIVATE, 512, 0, 0));
        push_cmd(make_cmd(OP_READ, 0, 64, 0));
        push_cmd(make_cmd(OP_READ_AP, 0, LAST_COL, 0));
        push_cmd(make_cmd(OP_WRITE_AP, 0, 1, 8'hA5));
        push_cmd(make_cmd(OP_PRECHARGE, 0, 0, 0));
        push_cmd(make_cmd(OP_ACTIVATE, 0, LAST_COL, 8'hFF));
        push_cmd(make_cmd(OP_READ, 0, 1, 0));
        push_cmd(make_cmd(OP_READ, 0, 64, 0));
        push_cmd(make_cmd(OP_WRITE, LAST_ROW, 0, 8'h81));
        push_cmd(make_cmd(OP_ACTIVATE, LAST_ROW, 0, 0));
        push_cmd(make_cmd(OP_READ_AP, 0, 0, 0));
        push_cmd(make_cmd(OP_READ, 0, LAST_COL, 0));
    endtask

    initial begin
        int target;
        int seq_len;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();

        // Random: mostly activate, a run of accesses, optional precharge; some noise.
        target = commands_sent + RANDOM_COMMANDS;
        while (commands_sent < target) begin
            if ($urandom_range(0, 99) < 85) begin
                push_cmd(make_cmd(OP_ACTIVATE, pick_written_row(), $urandom_range(0, LAST_COL),
                                  $urandom_range(0, 255)));
                seq_len = $urandom_range(1, 12);
                repeat (seq_len) push_access();
                if ($urandom_range(0, 1) == 0)
                    push_cmd(make_cmd(OP_PRECHARGE, $urandom_range(0, LAST_ROW),
                                      $urandom_range(0, LAST_COL), $urandom_range(0, 255)));
            end else begin
                push_noise();
            end
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding reads, then give the block time to show stray items.
        while (sb.pending_reads.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
